/* rtl/core/greedy_box_suppression_top_defines.svh */
// ----------------------------------------------------------------------------
// Greedy box suppression: assertion macros
// Concurrent check helpers shared by the suppression core. Each macro
// samples on aclk and is disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_TOP_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define GBS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("gbs: invariant violated");

// antecedent implies consequent in the same cycle
`define GBS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gbs: implication violated");

`endif

/* rtl/core/gbs_pkg.sv */
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared types and fixed constants of the suppression core.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int unsigned THR_W   = 16;
    localparam int unsigned INDEX_W = 16;

    localparam logic [THR_W-1:0]   THR_RESET = 16'd29491;  // ~0.45 in Q0.16
    localparam logic [INDEX_W-1:0] INDEX_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        GBS_IDLE,
        GBS_AREA,
        GBS_SCAN,
        GBS_DONE
    } gbs_state_t;

    // one compare result from the overlap pipe
    typedef struct packed {
        logic valid;
        logic over;
    } gbs_hit_t;

endpackage

/* rtl/core/greedy_box_suppression_top.sv */
// A box request passes setup, one store read per kept box, the registered
// read, the compare pipe and the drain check, then commit; with an empty store
// it goes from setup through the drain check to commit. A new box is taken
// only after the last one commits, which waits while the output is stalled.
// Reset (aresetn low, synchronous): empty store, set position 0, threshold
// 29491; kept-store contents are not cleared.
// ----------------------------------------------------------------------------
// Greedy box suppression core
// Greedy IoU suppression over boxes arriving in falling score order, with the
// kept boxes held in an on-chip memory and scanned one entry per cycle.
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_top_defines.svh"

module greedy_box_suppression_top #(
    parameter int unsigned MAX_KEPT   = 64,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // threshold write port
    input  logic                                   cfg_wen,
    input  logic        [gbs_pkg::THR_W-1:0]       cfg_wdata,
    // box requests
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_first_of_set,
    input  logic signed [COORD_BITS-1:0]           s_box_left,
    input  logic signed [COORD_BITS-1:0]           s_box_top,
    input  logic        [COORD_BITS-2:0]           s_box_width,
    input  logic        [COORD_BITS-2:0]           s_box_height,
    // verdicts
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_keep,
    output logic        [gbs_pkg::INDEX_W-1:0]     m_item_index,
    output logic                                   m_store_full
);

    localparam int unsigned C     = COORD_BITS;
    localparam int unsigned EW    = C + 1;                       // right/bottom edge
    localparam int unsigned AW    = 2 * C - 2;                   // area
    localparam int unsigned MW    = 2 * C + 2 * EW + AW;         // store word
    localparam int unsigned KC_W  = $clog2(MAX_KEPT + 1);        // kept count
    localparam int unsigned IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int unsigned IW    = gbs_pkg::INDEX_W;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    gbs_pkg::gbs_state_t state_reg, state_next;

    logic [gbs_pkg::THR_W-1:0] thr_reg;
    logic [KC_W-1:0] kept_count_reg, kept_count_next;
    logic [KC_W-1:0] issue_cnt_reg, issue_cnt_next;  // store reads issued
    logic [KC_W-1:0] resp_cnt_reg, resp_cnt_next;    // compare results seen
    logic            supp_reg, supp_next;            // sticky suppress
    logic [IW-1:0]   set_pos_reg, set_pos_next;
    logic [IW-1:0]   item_idx_reg, item_idx_next;
    logic [IW-1:0]   idx_base;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic          m_keep_reg, m_keep_next;
    logic [IW-1:0] m_item_index_reg, m_item_index_next;
    logic          m_store_full_reg, m_store_full_next;

    // ------------------------------------------------------------------
    // Current box (payload, no reset)
    // ------------------------------------------------------------------
    logic signed [C-1:0]  cur_left_reg, cur_top_reg;
    logic [C-2:0]         cur_w_reg, cur_h_reg;
    logic signed [EW-1:0] cur_right_reg, cur_bottom_reg;
    logic signed [EW-1:0] cur_right_next, cur_bottom_next;
    logic [AW-1:0]        cur_area_reg, cur_area_next;

    // ------------------------------------------------------------------
    // Kept store: {left, top, right, bottom, area}
    // ------------------------------------------------------------------
    logic [MW-1:0]    kept_mem [MAX_KEPT];
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [MW-1:0]    wr_data, rd_data_reg;
    logic             rd_valid_reg;

    gbs_pkg::gbs_hit_t hit;

    logic s_accept;
    logic out_free;
    logic room;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign room     = kept_count_reg != KC_W'(MAX_KEPT);

    // first box of a set restarts the position count
    assign idx_base = s_first_of_set ? '0 : set_pos_reg;

    // edges and area are formed once per box, in the setup cycle
    assign cur_right_next  = $signed({cur_left_reg[C-1], cur_left_reg})
                           + $signed({2'b00, cur_w_reg});
    assign cur_bottom_next = $signed({cur_top_reg[C-1], cur_top_reg})
                           + $signed({2'b00, cur_h_reg});
    assign cur_area_next   = AW'(cur_w_reg) * AW'(cur_h_reg);

    assign rd_addr = issue_cnt_reg[IDX_W-1:0];
    assign wr_addr = kept_count_reg[IDX_W-1:0];
    assign wr_data = {cur_left_reg, cur_top_reg, cur_right_reg, cur_bottom_reg,
                      cur_area_reg};

    // ------------------------------------------------------------------
    // Sequencer: IDLE takes a request, AREA prepares it, SCAN streams
    // every kept entry through the compare pipe, DONE commits the verdict.
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        kept_count_next   = kept_count_reg;
        issue_cnt_next    = issue_cnt_reg;
        resp_cnt_next     = resp_cnt_reg;
        supp_next         = supp_reg;
        set_pos_next      = set_pos_reg;
        item_idx_next     = item_idx_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_keep_next       = m_keep_reg;
        m_item_index_next = m_item_index_reg;
        m_store_full_next = m_store_full_reg;
        s_ready           = 1'b0;
        rd_en             = 1'b0;
        wr_en             = 1'b0;

        unique case (state_reg)
            gbs_pkg::GBS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next    = gbs_pkg::GBS_AREA;
                    item_idx_next = idx_base;
                    set_pos_next  = (idx_base == gbs_pkg::INDEX_MAX) ?
                                    idx_base : idx_base + IW'(1);
                    if (s_first_of_set) begin
                        kept_count_next = '0;
                    end
                end
            end
            gbs_pkg::GBS_AREA: begin
                issue_cnt_next = '0;
                resp_cnt_next  = '0;
                supp_next      = 1'b0;
                state_next     = gbs_pkg::GBS_SCAN;
            end
            gbs_pkg::GBS_SCAN: begin
                if (issue_cnt_reg != kept_count_reg) begin
                    rd_en          = 1'b1;
                    issue_cnt_next = issue_cnt_reg + KC_W'(1);
                end
                if (hit.valid) begin
                    resp_cnt_next = resp_cnt_reg + KC_W'(1);
                    supp_next     = supp_reg || hit.over;
                end
                // all reads issued and the pipe drained
                if ((issue_cnt_reg == kept_count_reg) &&
                    (resp_cnt_reg == kept_count_reg)) begin
                    state_next = gbs_pkg::GBS_DONE;
                end
            end
            gbs_pkg::GBS_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_keep_next       = !supp_reg;
                    m_item_index_next = item_idx_reg;
                    m_store_full_next = !supp_reg && !room;
                    if (!supp_reg && room) begin
                        wr_en           = 1'b1;
                        kept_count_next = kept_count_reg + KC_W'(1);
                    end
                    state_next = gbs_pkg::GBS_IDLE;
                end
            end
            default: begin
                state_next = gbs_pkg::GBS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gbs_pkg::GBS_IDLE;
            thr_reg        <= gbs_pkg::THR_RESET;
            kept_count_reg <= '0;
            issue_cnt_reg  <= '0;
            resp_cnt_reg   <= '0;
            supp_reg       <= 1'b0;
            set_pos_reg    <= '0;
            item_idx_reg   <= '0;
            m_valid_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wen) begin
                thr_reg <= cfg_wdata;
            end
            kept_count_reg <= kept_count_next;
            issue_cnt_reg  <= issue_cnt_next;
            resp_cnt_reg   <= resp_cnt_next;
            supp_reg       <= supp_next;
            set_pos_reg    <= set_pos_next;
            item_idx_reg   <= item_idx_next;
            m_valid_reg    <= m_valid_next;
            rd_valid_reg   <= rd_en;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_keep_reg       <= m_keep_next;
        m_item_index_reg <= m_item_index_next;
        m_store_full_reg <= m_store_full_next;
        if (s_accept) begin
            cur_left_reg <= s_box_left;
            cur_top_reg  <= s_box_top;
            cur_w_reg    <= s_box_width;
            cur_h_reg    <= s_box_height;
        end
        if (state_reg == gbs_pkg::GBS_AREA) begin
            cur_right_reg  <= cur_right_next;
            cur_bottom_reg <= cur_bottom_next;
            cur_area_reg   <= cur_area_next;
        end
    end

    // kept store: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            kept_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= kept_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Compare pipe
    // ------------------------------------------------------------------
    gbs_iou_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_iou_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rd_valid_reg),
        .thr        (thr_reg),
        .cur_left   (cur_left_reg),
        .cur_top    (cur_top_reg),
        .cur_right  (cur_right_reg),
        .cur_bottom (cur_bottom_reg),
        .cur_area   (cur_area_reg),
        .k_left     ($signed(rd_data_reg[MW-1 -: C])),
        .k_top      ($signed(rd_data_reg[MW-C-1 -: C])),
        .k_right    ($signed(rd_data_reg[MW-2*C-1 -: EW])),
        .k_bottom   ($signed(rd_data_reg[MW-2*C-EW-1 -: EW])),
        .k_area     (rd_data_reg[AW-1:0]),
        .hit        (hit)
    );

    assign m_valid      = m_valid_reg;
    assign m_keep       = m_keep_reg;
    assign m_item_index = m_item_index_reg;
    assign m_store_full = m_store_full_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GBS_ASSERT_ALWAYS(a_count_bound, kept_count_reg <= KC_W'(MAX_KEPT))
    `GBS_ASSERT_IMPLY(a_full_is_kept, m_valid_reg && m_store_full_reg, m_keep_reg)
    `GBS_ASSERT_IMPLY(a_hit_in_scan, hit.valid, state_reg == gbs_pkg::GBS_SCAN)
    `GBS_ASSERT_IMPLY(a_resp_le_issue, state_reg == gbs_pkg::GBS_SCAN,
                      resp_cnt_reg <= issue_cnt_reg)

endmodule

/* rtl/core/gbs_iou_pipe.sv */
// ----------------------------------------------------------------------------
// Overlap test pipeline
// Five-stage compare of the current box against one kept entry per cycle:
// overlap extents, intersection, union, threshold product, final compare.
// ----------------------------------------------------------------------------
module gbs_iou_pipe #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    input  logic        [gbs_pkg::THR_W-1:0]       thr,
    input  logic signed [COORD_BITS-1:0]           cur_left,
    input  logic signed [COORD_BITS-1:0]           cur_top,
    input  logic signed [COORD_BITS:0]             cur_right,
    input  logic signed [COORD_BITS:0]             cur_bottom,
    input  logic        [2*COORD_BITS-3:0]         cur_area,
    input  logic signed [COORD_BITS-1:0]           k_left,
    input  logic signed [COORD_BITS-1:0]           k_top,
    input  logic signed [COORD_BITS:0]             k_right,
    input  logic signed [COORD_BITS:0]             k_bottom,
    input  logic        [2*COORD_BITS-3:0]         k_area,
    output gbs_pkg::gbs_hit_t                      hit
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned DW = C - 1;               // overlap extent
    localparam int unsigned AW = 2 * C - 2;           // area
    localparam int unsigned UW = AW + 1;              // union
    localparam int unsigned UH = (UW + 1) / 2;        // low half of union
    localparam int unsigned HW = UW - UH;             // high half of union
    localparam int unsigned TW = gbs_pkg::THR_W;
    localparam int unsigned CW = AW + TW + 1;         // compare width

    // stage valids
    logic [4:0] vld_reg;

    // stage 1: overlap extents
    logic signed [C-1:0] x0, y0;
    logic signed [C:0]   x1, y1;
    logic signed [C+1:0] dx, dy;
    logic [DW-1:0]       ow_next, oh_next;
    logic [DW-1:0]       ow_reg, oh_reg;
    logic [AW-1:0]       karea1_reg;

    // stage 2: intersection
    logic [AW-1:0]       inter_next;
    logic [AW-1:0]       inter2_reg, karea2_reg;

    // stage 3: union
    logic [UW-1:0]       uni_next;
    logic [UW-1:0]       uni_reg;
    logic [AW-1:0]       inter3_reg;

    // stage 4: threshold * union, split in halves
    logic [TW+UH-1:0]    plo_next, plo_reg;
    logic [TW+HW-1:0]    phi_next, phi_reg;
    logic [AW-1:0]       inter4_reg;

    // stage 5: compare
    logic [CW-1:0]       lhs, rhs;
    logic                over_next, over_reg;

    assign x0 = (cur_left > k_left) ? cur_left : k_left;
    assign y0 = (cur_top > k_top) ? cur_top : k_top;
    assign x1 = (cur_right < k_right) ? cur_right : k_right;
    assign y1 = (cur_bottom < k_bottom) ? cur_bottom : k_bottom;
    assign dx = $signed({x1[C], x1}) - $signed({{2{x0[C-1]}}, x0});
    assign dy = $signed({y1[C], y1}) - $signed({{2{y0[C-1]}}, y0});
    // empty overlap clamps to zero
    assign ow_next = (!dx[C+1] && (dx != '0)) ? dx[DW-1:0] : '0;
    assign oh_next = (!dy[C+1] && (dy != '0)) ? dy[DW-1:0] : '0;

    assign inter_next = AW'(ow_reg) * AW'(oh_reg);

    assign uni_next = UW'(cur_area) + UW'(karea2_reg) - UW'(inter2_reg);

    assign plo_next = (TW+UH)'(thr) * (TW+UH)'(uni_reg[UH-1:0]);
    assign phi_next = (TW+HW)'(thr) * (TW+HW)'(uni_reg[UW-1:UH]);

    assign lhs       = CW'({inter4_reg, {TW{1'b0}}});
    assign rhs       = CW'(plo_reg) + (CW'(phi_reg) << UH);
    assign over_next = lhs > rhs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        ow_reg     <= ow_next;
        oh_reg     <= oh_next;
        karea1_reg <= k_area;
        inter2_reg <= inter_next;
        karea2_reg <= karea1_reg;
        uni_reg    <= uni_next;
        inter3_reg <= inter2_reg;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        inter4_reg <= inter3_reg;
        over_reg   <= over_next;
    end

    assign hit.valid = vld_reg[4];
    assign hit.over  = over_reg;

endmodule

/* sim/tb_greedy_box_suppression_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy box suppression testbench
// Drives box requests into greedy_box_suppression_top and checks every
// verdict against an in-bench model of greedy IoU suppression. A short
// directed table comes first. Random sets follow under several thresholds,
// the extremes among them.
// ----------------------------------------------------------------------------
module tb_greedy_box_suppression_top;

    localparam int unsigned MAX_KEPT   = 64;
    localparam int unsigned COORD_BITS = 16;

    // one box request, at port widths
    typedef struct {
        logic                         first;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic        [COORD_BITS-2:0] width;
        logic        [COORD_BITS-2:0] height;
    } box_req_t;

    // one verdict
    typedef struct {
        logic                        keep;
        logic [gbs_pkg::INDEX_W-1:0] index;
        logic                        full;
    } verdict_t;

    // directed row; verdict fields only used when typed is set
    typedef struct {
        int first, left, top, width, height;
        bit typed;
        bit keep;
        int index;
        bit full;
    } dir_row_t;

    typedef enum {SET_CLUSTER, SET_GRID, SET_NOISE} set_kind_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          cfg_wen = 1'b0;
    logic [gbs_pkg::THR_W-1:0]     cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_first_of_set = 1'b0;
    logic signed [COORD_BITS-1:0]  s_box_left = '0;
    logic signed [COORD_BITS-1:0]  s_box_top = '0;
    logic        [COORD_BITS-2:0]  s_box_width = '0;
    logic        [COORD_BITS-2:0]  s_box_height = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_keep;
    logic [gbs_pkg::INDEX_W-1:0]   m_item_index;
    logic                          m_store_full;

    // model state: kept store, set position, threshold
    longint   kept_left [MAX_KEPT];
    longint   kept_top  [MAX_KEPT];
    longint   kept_wid  [MAX_KEPT];
    longint   kept_hgt  [MAX_KEPT];
    longint   kept_area [MAX_KEPT];
    int       kept_n  = 0;
    int       set_pos = 0;
    longint   iou_thr = longint'(gbs_pkg::THR_RESET);

    verdict_t verdicts_due[$];     // verdicts owed by the block, oldest first
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;      // both sides run flat out while set
    int       ready_hold = 0;      // cycles left in the current output stall

    // threshold 29491 out of reset; rows up to the first set restart lean on it
    dir_row_t directed_rows [16] = '{
        //  first   left     top     width  height typed keep idx full
        '{0,      0,      0,   160,   160, 1, 1, 0, 0},  // no first flag after reset
        '{0,      0,      0,   160,   160, 1, 0, 1, 0},  // identical box, IoU 1
        '{0, -32768, -32768, 32767, 32767, 1, 1, 2, 0},  // most negative corner, max size
        '{0,  32767,  32767, 32767, 32767, 1, 1, 3, 0},  // most positive corner, max size
        '{0,      0,      0,     0,     0, 0, 0, 0, 0},  // zero area, edge contact only
        '{0,      0,      0,     0,     0, 0, 0, 0, 0},  // zero union against the last one
        '{0,     80,      0,   160,   160, 0, 0, 0, 0},  // IoU 1/3, survives
        '{0,     40,      0,   160,   160, 0, 0, 0, 0},  // IoU 0.6, suppressed
        '{0,    160,      0,   160,   160, 0, 0, 0, 0},  // touches first box: empty overlap
        '{0,     10,   -100,     0, 32767, 0, 0, 0, 0},  // zero width, tallest
        '{1,      0,      0,   160,   160, 1, 1, 0, 0},  // set restart empties store
        '{0,      0,      0,   160,   160, 1, 0, 1, 0},  // identical, suppressed
        '{1, -32768, -32768,     0,     0, 1, 1, 0, 0},  // restart with zero-area corner
        '{0, -32768, -32768, 32767, 32767, 0, 0, 0, 0},
        '{0, -32768, -32768, 32767, 32767, 0, 0, 0, 0},  // identical at extreme coords
        '{0, -32767, -32768, 32767, 32767, 0, 0, 0, 0}   // near identical
    };

    greedy_box_suppression_top #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_of_set (s_first_of_set),
        .s_box_left     (s_box_left),
        .s_box_top      (s_box_top),
        .s_box_width    (s_box_width),
        .s_box_height   (s_box_height),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keep         (m_keep),
        .m_item_index   (m_item_index),
        .m_store_full   (m_store_full)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Greedy IoU verdict for one accepted box; updates the kept store.
    // Suppress when inter * 2^16 > thr * union, thr in Q0.16, areas exact integers.
    function automatic verdict_t judge_box(input box_req_t r);
        longint   bl, bt, bw, bh, area;
        longint   x0, y0, x1, y1, inter, uni;
        verdict_t v;
        if (r.first) begin
            kept_n  = 0;
            set_pos = 0;
        end
        bl   = longint'(r.left);
        bt   = longint'(r.top);
        bw   = longint'(r.width);
        bh   = longint'(r.height);
        area = bw * bh;
        v.keep = 1'b1;
        v.full = 1'b0;
        for (int i = 0; i < kept_n; i++) begin
            x0 = (bl > kept_left[i]) ? bl : kept_left[i];
            y0 = (bt > kept_top[i]) ? bt : kept_top[i];
            x1 = (bl + bw < kept_left[i] + kept_wid[i]) ? bl + bw : kept_left[i] + kept_wid[i];
            y1 = (bt + bh < kept_top[i] + kept_hgt[i]) ? bt + bh : kept_top[i] + kept_hgt[i];
            inter = (x1 > x0 && y1 > y0) ? (x1 - x0) * (y1 - y0) : 64'sd0;
            uni   = area + kept_area[i] - inter;
            if ((inter << 16) > iou_thr * uni) begin
                v.keep = 1'b0;
                break;
            end
        end
        if (v.keep) begin
            if (kept_n < MAX_KEPT) begin
                kept_left[kept_n] = bl;
                kept_top[kept_n]  = bt;
                kept_wid[kept_n]  = bw;
                kept_hgt[kept_n]  = bh;
                kept_area[kept_n] = area;
                kept_n++;
            end else begin
                v.full = 1'b1;   // survivor with no room left
            end
        end
        v.index = set_pos[gbs_pkg::INDEX_W-1:0];
        if (set_pos < int'(gbs_pkg::INDEX_MAX))
            set_pos++;
        return v;
    endfunction

    // Random box of one set. Clusters overlap a lot, grid tiles never
    // overlap (fills the store), noise spans every bit of every field.
    function automatic box_req_t make_box(input set_kind_t kind, input int j);
        box_req_t r;
        int       x, y, w, h;
        case (kind)
            SET_GRID: begin
                // 400-unit pitch, box plus jitter stays under 400
                x = (j % 10) * 400 - 2000 + $urandom_range(0, 50);
                y = (j / 10) * 400 - 2000 + $urandom_range(0, 50);
                w = $urandom_range(16, 340);
                h = $urandom_range(16, 340);
            end
            SET_CLUSTER: begin
                x = $urandom_range(0, 1200);
                y = $urandom_range(0, 1200);
                w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(16, 640);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(16, 640);
            end
            default: begin
                x = $urandom;
                y = $urandom;
                w = $urandom;
                h = $urandom;
            end
        endcase
        r.first  = 1'b0;
        r.left   = x[COORD_BITS-1:0];
        r.top    = y[COORD_BITS-1:0];
        r.width  = w[COORD_BITS-2:0];
        r.height = h[COORD_BITS-2:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Present one request, hold it until accepted, then log its verdict.
    // Entered and left at a falling edge.
    task automatic send_box(input box_req_t r, input bit typed, input verdict_t typed_v);
        int       gap;
        int       p;
        verdict_t v;
        p   = $urandom_range(0, 99);
        gap = no_idle ? 0 : (p < 55) ? 0 : (p < 92) ? $urandom_range(1, 3)
                                                    : $urandom_range(12, 50);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_first_of_set <= r.first;
        s_box_left     <= r.left;
        s_box_top      <= r.top;
        s_box_width    <= r.width;
        s_box_height   <= r.height;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        v = judge_box(r);
        // typed rows still run the model so its store stays in step
        verdicts_due = {verdicts_due, (typed ? typed_v : v)};
        @(negedge aclk);
    endtask

    // Drop valid and wait until every owed verdict is in.
    task automatic drain;
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Threshold write, only with the block idle.
    task automatic set_threshold(input logic [gbs_pkg::THR_W-1:0] thr);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        iou_thr = longint'(thr);
    endtask

    // Output stalls: mostly short, a few long, none while no_idle is set.
    always @(negedge aclk) begin
        if (no_idle) begin
            ready_hold = 0;
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            ready_hold = ($urandom_range(0, 24) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(0, 2);
        end
    end

    // Verdict checker: each accepted verdict against the oldest owed one.
    always @(posedge aclk) begin : check_verdict
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("verdict with no request outstanding");
            end else begin
                want = verdicts_due.pop_front();
                if (m_keep !== want.keep)
                    report_mismatch($sformatf("keep got %b want %b (index %0d)",
                                              m_keep, want.keep, want.index));
                if (m_item_index !== want.index)
                    report_mismatch($sformatf("item_index got %0d want %0d",
                                              m_item_index, want.index));
                if (m_store_full !== want.full)
                    report_mismatch($sformatf("store_full got %b want %b (index %0d)",
                                              m_store_full, want.full, want.index));
            end
        end
    end

    initial begin
        box_req_t   r;
        verdict_t   tv;
        dir_row_t   row;
        set_kind_t  kind;
        int         made, len, p;
        bit         fresh;
        logic [gbs_pkg::THR_W-1:0] thr_list [4];

        tv = '{keep: 1'b0, index: '0, full: 1'b0};

        // reset held low from the start, released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table at the reset threshold
        foreach (directed_rows[k]) begin
            row      = directed_rows[k];
            r.first  = row.first[0];
            r.left   = row.left[COORD_BITS-1:0];
            r.top    = row.top[COORD_BITS-1:0];
            r.width  = row.width[COORD_BITS-2:0];
            r.height = row.height[COORD_BITS-2:0];
            tv.keep  = row.keep;
            tv.index = row.index[gbs_pkg::INDEX_W-1:0];
            tv.full  = row.full;
            send_box(r, row.typed, tv);
        end

        // random phases: threshold extremes, a random one, and back to default
        thr_list[0] = '0;
        thr_list[1] = '1;
        thr_list[2] = (gbs_pkg::THR_W)'($urandom_range(1, 65534));
        thr_list[3] = gbs_pkg::THR_RESET;
        for (int ph = 0; ph < 4; ph++) begin
            set_threshold(thr_list[ph]);
            // open with a disjoint set long enough to overflow the store
            no_idle = 1'b0;
            for (int j = 0; j < 70; j++) begin
                r = make_box(SET_GRID, j);
                r.first = (j == 0);
                send_box(r, 1'b0, tv);
            end
            made = 70;
            while (made < 200) begin
                p    = $urandom_range(0, 9);
                kind = (p < 6) ? SET_CLUSTER : (p < 8) ? SET_GRID : SET_NOISE;
                len  = (kind == SET_GRID) ? $urandom_range(30, 72) :
                       (kind == SET_CLUSTER) ? $urandom_range(1, 40) : $urandom_range(1, 20);
                no_idle = ($urandom_range(0, 4) == 0);
                // now and then a set runs on without its first flag
                fresh   = ($urandom_range(0, 9) != 0);
                for (int j = 0; j < len; j++) begin
                    r = make_box(kind, j);
                    r.first = (j == 0) ? fresh
                                       : (kind == SET_NOISE && $urandom_range(0, 7) == 0);
                    send_box(r, 1'b0, tv);
                    made++;
                end
            end
        end

        drain();
        no_idle = 1'b0;
        repeat (MAX_KEPT + 20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_greedy_box_suppression_top: done, clean");
        end else begin
            $display("tb_greedy_box_suppression_top: done, errors");
        end
        $finish;
    end

    // run limit, several times the slowest legal run
    initial begin
        #40_000_000;
        $display("tb_greedy_box_suppression_top: done, errors");
        $finish;
    end

endmodule
